// ===== rtl/gclk_pkg.sv =====
`timescale 1ns / 1ps
package gclk_pkg;

  // Field widths.
  localparam int TimeW    = 32;
  localparam int PeriodW  = 20;
  localparam int AngleW   = 16;
  localparam int OutAngW  = 18;
  localparam int TsW      = 22;  // adjusted stance period, signed
  localparam int PhioW    = 17;  // adjusted stance offset, signed
  localparam int SumW     = 33;  // time plus phase shift
  localparam int MulAW    = 22;
  localparam int MulBW    = 17;
  localparam int ProdW    = 39;
  localparam int DivW     = 23;  // divider remainder width
  localparam int QClampW  = 19;

  // Register indexes.
  localparam logic [2:0] RegSweep   = 3'd0;
  localparam logic [2:0] RegOffset  = 3'd1;
  localparam logic [2:0] RegGait    = 3'd2;
  localparam logic [2:0] RegStance  = 3'd3;
  localparam logic [2:0] RegTimeOff = 3'd4;

  // Gait modes.
  localparam logic [1:0] ModePre  = 2'd0;
  localparam logic [1:0] ModeSlow = 2'd1;
  localparam logic [1:0] ModePost = 2'd2;

  // Two pi in Q13.
  localparam logic signed [MulBW-1:0] TwoPiQ13 = 17'sd51472;

  // Reset values of the registers.
  localparam logic [15:0]        SweepRst   = 16'd8192;
  localparam logic [PeriodW-1:0] GaitRst    = 20'd65536;
  localparam logic [PeriodW-1:0] StanceRst  = 20'd32768;

  // Item state through the modulo stages.
  typedef struct packed {
    logic                    v;
    logic [SumW-1:0]         num;
    logic [PeriodW-1:0]      rem;
    logic signed [TsW-1:0]   ts;
    logic signed [PhioW-1:0] phio;
    logic                    bad;
  } mod_st_t;

  // Item state after the mode decision, before the multiply.
  typedef struct packed {
    logic                    v;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
    logic [TsW-2:0]          hd;   // half of the divisor
    logic [1:0]              mode;
    logic signed [PhioW-1:0] phio;
    logic                    bad;
  } mul_st_t;

  // Item state through the divider stages.
  typedef struct packed {
    logic                    v;
    logic [ProdW-1:0]        num;
    logic [ProdW-1:0]        quo;
    logic [DivW-1:0]         rem;
    logic [TsW-1:0]          den;
    logic                    neg;
    logic [1:0]              mode;
    logic signed [PhioW-1:0] phio;
    logic                    bad;
  } div_st_t;

endpackage

// ===== rtl/gait_clock_leg_angle.sv =====
`timescale 1ns / 1ps
// Gait clock for one leg: each input word (time, stance period trim, stance
// offset trim) yields one output word with the leg angle, the gait mode and a
// bad period flag. The block is a pipeline of 77 stages that accepts one word
// every cycle unless the output stalls: 1 input stage, 33 stages of the
// bit-serial time modulo, a mode stage, a multiply stage, a rounding stage, 39
// stages of the bit-serial divider and the output register. A stall on the
// output side holds the whole pipeline, so in_tready follows out_tready whenever
// the output register is full. Configuration may only be written while idle.
module gait_clock_leg_angle (
  input  logic        clk,
  input  logic        rst_n,
  // time_now[31:0], stance_time_adjust[51:32], stance_angle_adjust[67:52]
  input  logic [71:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // leg_angle[17:0], gait_mode[19:18], bad_period[20]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int ModN = gclk_pkg::SumW;
  localparam int DivN = gclk_pkg::ProdW;

  // Configuration registers.
  logic [15:0]                 stance_sweep_r;
  logic signed [15:0]          stance_offset_r;
  logic [gclk_pkg::PeriodW-1:0] gait_period_r;
  logic [gclk_pkg::PeriodW-1:0] stance_period_r;
  logic [gclk_pkg::PeriodW-1:0] time_offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stance_sweep_r  <= gclk_pkg::SweepRst;
      stance_offset_r <= '0;
      gait_period_r   <= gclk_pkg::GaitRst;
      stance_period_r <= gclk_pkg::StanceRst;
      time_offset_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gclk_pkg::RegSweep:   stance_sweep_r  <= cfg_data[15:0];
        gclk_pkg::RegOffset:  stance_offset_r <= $signed(cfg_data[15:0]);
        gclk_pkg::RegGait:    gait_period_r   <= cfg_data;
        gclk_pkg::RegStance:  stance_period_r <= cfg_data;
        gclk_pkg::RegTimeOff: time_offset_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register can take a word.
  logic adv;
  logic out_v_r;
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  // Input stage: sum time, adjust stance period and offset, check the period.
  gclk_pkg::mod_st_t mod_r [ModN+1];
  gclk_pkg::mod_st_t in_nxt;
  logic signed [gclk_pkg::TsW-1:0] ts_c;

  always_comb begin
    ts_c = $signed({2'b00, stance_period_r}) +
           $signed({{2{in_tdata[51]}}, in_tdata[51:32]});
    in_nxt.v    = in_tvalid;
    in_nxt.num  = {1'b0, in_tdata[31:0]} + {13'd0, time_offset_r};
    in_nxt.rem  = '0;
    in_nxt.ts   = ts_c;
    in_nxt.phio = $signed({stance_offset_r[15], stance_offset_r}) +
                  $signed({in_tdata[67], in_tdata[67:52]});
    in_nxt.bad  = (ts_c <= 0) || (ts_c >= $signed({2'b00, gait_period_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r[0].v <= 1'b0;
    end else if (adv) begin
      mod_r[0] <= in_nxt;
    end
  end

  // Modulo stages: one dividend bit per stage, remainder stays below the period.
  for (genvar k = 0; k < ModN; k++) begin : g_mod
    gclk_pkg::mod_st_t nxt;
    logic [gclk_pkg::PeriodW:0] sh;
    always_comb begin
      nxt = mod_r[k];
      sh  = {mod_r[k].rem, mod_r[k].num[ModN-1-k]};
      if (sh >= {1'b0, gait_period_r}) begin
        sh = sh - {1'b0, gait_period_r};
      end
      nxt.rem = sh[gclk_pkg::PeriodW-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mod_r[k+1].v <= 1'b0;
      end else if (adv) begin
        mod_r[k+1] <= nxt;
      end
    end
  end

  // Mode stage: twice the phase, mode choice and multiplier operands.
  gclk_pkg::mod_st_t mend;
  gclk_pkg::mul_st_t mul_r;
  gclk_pkg::mul_st_t mul_nxt;
  logic signed [gclk_pkg::TsW-1:0] two_m;
  logic signed [gclk_pkg::TsW-1:0] p2;
  logic signed [gclk_pkg::TsW-1:0] two_tc;
  logic signed [gclk_pkg::MulBW-1:0] swing;

  assign mend = mod_r[ModN];

  always_comb begin
    two_m  = $signed({1'b0, mend.rem, 1'b0});
    two_tc = $signed({1'b0, gait_period_r, 1'b0});
    p2     = two_m - $signed({2'b00, gait_period_r});
    swing  = gclk_pkg::TwoPiQ13 - $signed({1'b0, stance_sweep_r});
    mul_nxt.v    = mend.v;
    mul_nxt.phio = mend.phio;
    mul_nxt.bad  = mend.bad;
    if (p2 < -mend.ts) begin
      mul_nxt.mode = gclk_pkg::ModePre;
      mul_nxt.a    = two_m;
      mul_nxt.b    = swing;
      mul_nxt.hd   = {1'b0, gait_period_r} - mend.ts[gclk_pkg::TsW-2:0];
    end else if (p2 < mend.ts) begin
      mul_nxt.mode = gclk_pkg::ModeSlow;
      mul_nxt.a    = p2;
      mul_nxt.b    = $signed({1'b0, stance_sweep_r});
      mul_nxt.hd   = mend.ts[gclk_pkg::TsW-2:0];
    end else begin
      mul_nxt.mode = gclk_pkg::ModePost;
      mul_nxt.a    = two_m - two_tc;
      mul_nxt.b    = swing;
      mul_nxt.hd   = {1'b0, gait_period_r} - mend.ts[gclk_pkg::TsW-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.v <= 1'b0;
    end else if (adv) begin
      mul_r <= mul_nxt;
    end
  end

  // Multiply stage.
  logic                             prd_v_r;
  logic signed [gclk_pkg::ProdW-1:0] prd_r;
  logic [gclk_pkg::TsW-2:0]          prd_hd_r;
  logic [1:0]                        prd_mode_r;
  logic signed [gclk_pkg::PhioW-1:0] prd_phio_r;
  logic                              prd_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_v_r <= 1'b0;
    end else if (adv) begin
      prd_v_r    <= mul_r.v;
      prd_r      <= mul_r.a * mul_r.b;
      prd_hd_r   <= mul_r.hd;
      prd_mode_r <= mul_r.mode;
      prd_phio_r <= mul_r.phio;
      prd_bad_r  <= mul_r.bad;
    end
  end

  // Rounding stage: magnitude plus half the divisor, sign kept aside.
  gclk_pkg::div_st_t div_r [DivN+1];
  gclk_pkg::div_st_t rnd_nxt;
  logic [gclk_pkg::ProdW-1:0] mag;

  always_comb begin
    mag = prd_r[gclk_pkg::ProdW-1] ? $unsigned(-prd_r) : $unsigned(prd_r);
    rnd_nxt.v    = prd_v_r;
    rnd_nxt.num  = mag + {{(gclk_pkg::ProdW-gclk_pkg::TsW+1){1'b0}}, prd_hd_r};
    rnd_nxt.quo  = '0;
    rnd_nxt.rem  = '0;
    rnd_nxt.den  = {prd_hd_r, 1'b0};
    rnd_nxt.neg  = prd_r[gclk_pkg::ProdW-1];
    rnd_nxt.mode = prd_mode_r;
    rnd_nxt.phio = prd_phio_r;
    rnd_nxt.bad  = prd_bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].v <= 1'b0;
    end else if (adv) begin
      div_r[0] <= rnd_nxt;
    end
  end

  // Divider stages: restoring division, one quotient bit per stage.
  for (genvar j = 0; j < DivN; j++) begin : g_div
    gclk_pkg::div_st_t nxt;
    logic [gclk_pkg::DivW-1:0] sh;
    always_comb begin
      nxt = div_r[j];
      sh  = {div_r[j].rem[gclk_pkg::DivW-2:0], div_r[j].num[DivN-1-j]};
      nxt.quo[DivN-1-j] = 1'b0;
      if (sh >= {1'b0, div_r[j].den}) begin
        sh = sh - {1'b0, div_r[j].den};
        nxt.quo[DivN-1-j] = 1'b1;
      end
      nxt.rem = sh;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[j+1].v <= 1'b0;
      end else if (adv) begin
        div_r[j+1] <= nxt;
      end
    end
  end

  // Output stage: sign, add the offset (subtract it in slow mode), saturate, flag a bad period.
  gclk_pkg::div_st_t dend;
  logic [gclk_pkg::QClampW-1:0]        qc;
  logic signed [gclk_pkg::QClampW:0]   sq;
  logic signed [gclk_pkg::QClampW+1:0] sum;
  logic signed [gclk_pkg::OutAngW-1:0] ang;
  logic [gclk_pkg::OutAngW-1:0] ang_r;
  logic [1:0]                   mode_r;
  logic                         bad_r;

  assign dend = div_r[DivN];

  always_comb begin
    if (dend.quo >= (DivN'(1) << (gclk_pkg::QClampW-1))) begin
      qc = {1'b1, {(gclk_pkg::QClampW-1){1'b0}}};
    end else begin
      qc = dend.quo[gclk_pkg::QClampW-1:0];
    end
    sq = dend.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    if (dend.mode == gclk_pkg::ModeSlow) begin
      sum = $signed({sq[gclk_pkg::QClampW], sq}) - dend.phio;
    end else begin
      sum = $signed({sq[gclk_pkg::QClampW], sq}) + dend.phio;
    end
    if (sum > 21'sd131071) begin
      ang = 18'sd131071;
    end else if (sum < -21'sd131072) begin
      ang = -18'sd131072;
    end else begin
      ang = sum[gclk_pkg::OutAngW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dend.v;
      ang_r   <= dend.bad ? '0 : ang;
      mode_r  <= dend.bad ? gclk_pkg::ModePre : dend.mode;
      bad_r   <= dend.bad;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, bad_r, mode_r, ang_r};

endmodule

// ===== rtl/gclk_chk.sv =====
`timescale 1ns / 1ps
module gclk_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic [23:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // A bad period gives a zero angle in the pre-stance code.
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> out_tdata[19:0] == 20'd0)
    else $error("bad period word carries an angle or mode");

  // The mode field never holds the unused code.
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:18] != 2'd3)
    else $error("unused gait mode code");

  // The pipeline never blocks input while the output side is taking words.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with output ready");

endmodule

bind gait_clock_leg_angle gclk_chk u_gclk_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== tb/sv/gait_clock_checker.sv =====
`timescale 1ns / 1ps
module gait_clock_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [71:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  // Fields from the lowest bit up: angle, mode, bad.
  typedef struct packed {
    logic        bad;
    logic [1:0]  mode;
    logic [17:0] angle;
  } leg_word_t;

  // Local copy of the configuration registers.
  longint unsigned sweep_q13;
  longint          offset_q13;
  longint unsigned gait_q16;
  longint unsigned stance_q16;
  longint unsigned shift_q16;

  leg_word_t angle_queue[$];

  // Rounded division, ties away from zero, for a positive divisor.
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  function automatic leg_word_t predict_angle(logic [71:0] w);
    longint unsigned t;
    longint ts, phio, tc, p2, swing, ang;
    leg_word_t r;
    t = w[31:0];
    ts = longint'(stance_q16) + longint'($signed(w[51:32]));
    phio = offset_q13 + longint'($signed(w[67:52]));
    tc = longint'(gait_q16);
    r = '0;
    if (ts <= 0 || ts >= tc) begin
      r.bad = 1'b1;
      r.mode = gclk_pkg::ModePre;
      return r;
    end
    p2 = 2 * longint'((t + shift_q16) % gait_q16) - tc;
    swing = 51472 - longint'(sweep_q13);
    if (p2 < -ts) begin
      r.mode = gclk_pkg::ModePre;
      ang = phio + round_div((p2 + tc) * swing, 2 * (tc - ts));
    end else if (p2 < ts) begin
      r.mode = gclk_pkg::ModeSlow;
      ang = round_div(longint'(sweep_q13) * p2, 2 * ts) - phio;
    end else begin
      r.mode = gclk_pkg::ModePost;
      ang = phio + round_div((p2 - tc) * swing, 2 * (tc - ts));
    end
    if (ang > 131071) ang = 131071;
    if (ang < -131072) ang = -131072;
    r.angle = ang[17:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Track config, predict accepted words, compare delivered words.
  always @(posedge clk) begin
    leg_word_t got, want;
    if (!rst_n) begin
      sweep_q13 <= 8192;
      offset_q13 <= 0;
      gait_q16 <= 65536;
      stance_q16 <= 32768;
      shift_q16 <= 0;
      angle_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gclk_pkg::RegSweep:   sweep_q13 <= cfg_data[15:0];
          gclk_pkg::RegOffset:  offset_q13 <= longint'($signed(cfg_data[15:0]));
          gclk_pkg::RegGait:    gait_q16 <= cfg_data;
          gclk_pkg::RegStance:  stance_q16 <= cfg_data;
          gclk_pkg::RegTimeOff: shift_q16 <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        angle_queue.push_back(predict_angle(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[20:0];
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected word", got, 0);
        end else begin
          want = angle_queue.pop_front();
          if (got.angle !== want.angle)
            report_mismatch("leg_angle", $signed(got.angle), $signed(want.angle));
          if (got.mode !== want.mode) report_mismatch("gait_mode", got.mode, want.mode);
          if (got.bad !== want.bad) report_mismatch("bad_period", got.bad, want.bad);
        end
      end
    end
    pending_count = angle_queue.size();
  end
endmodule

// ===== tb/sv/tb_gait_clock_leg_angle.sv =====
`timescale 1ns / 1ps
module tb_gait_clock_leg_angle;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [71:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  logic        stim_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gait_clock_leg_angle DUT (.*);

  gait_clock_checker u_checker (.*);

  // Current gait period, to steer times around the phase boundaries.
  longint unsigned gait_now = 65536;

  // Receiver: random stalls before each word, some stretches without.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gclk_pkg::RegGait) gait_now = val;
    @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] t, logic [19:0] tadj, logic [15:0] aadj, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, aadj, tadj, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drain the pipeline so configuration can change while idle.
  task automatic drain_pipe;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic random_word(bit gaps);
    logic [31:0] t;
    logic [19:0] tadj;
    logic [15:0] aadj;
    t = $urandom;
    // Most adjustments are small so the stance period stays valid.
    tadj = ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($signed($urandom_range(0, 4000)) - 2000);
    aadj = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    if ($urandom_range(0, 2) == 0 && gait_now > 2)
      t = 32'($urandom_range(0, 100) * gait_now + $urandom_range(0, 3)
              + ($urandom_range(0, 1) ? gait_now / 2 : 0) - 1);
    send_word(t, tadj, aadj, gaps);
  endtask

  // Stimulus.
  initial begin
    bit nogap;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings: field extremes and all modes.
    send_word(32'h0, 20'h0, 16'h0, 1'b0);
    send_word(32'hFFFF_FFFF, 20'h0, 16'h0, 1'b0);
    send_word(32'd16384, 20'h0, 16'h7FFF, 1'b1);
    send_word(32'd32768, 20'h0, 16'h8000, 1'b1);
    send_word(32'd49152, 20'h0, 16'h0, 1'b0);
    send_word(32'd16383, 20'h0, 16'h0, 1'b0);
    send_word(32'd49151, 20'h0, 16'h0, 1'b0);
    send_word(32'd1000, 20'h7FFFF, 16'h0, 1'b0);   // bad period, too long
    send_word(32'd1000, 20'h80000, 16'h0, 1'b0);   // bad period, negative
    send_word(32'd1000, -20'sd32768, 16'h0, 1'b0); // bad period, zero
    send_word(32'd1000, 20'd32767, 16'h0, 1'b0);   // stance one short of the cycle
    send_word(32'd1000, 20'd32766, 16'h0, 1'b0);
    send_word(32'd40000, -20'sd32767, 16'h0, 1'b0);
    drain_pipe();

    // Large sweep, extreme offsets and shifts.
    write_reg(gclk_pkg::RegSweep, 20'hFFFF);
    write_reg(gclk_pkg::RegOffset, 20'h7FFF);
    write_reg(gclk_pkg::RegTimeOff, 20'hFFFFF);
    write_reg(3'd7, 20'h12345);          // unused index, ignored
    send_word(32'd5, 20'h0, 16'h7FFF, 1'b0);
    send_word(32'd30000, 20'h0, 16'h0, 1'b0);
    send_word(32'hFFFF_FFFF, 20'h0, 16'h8000, 1'b0);
    drain_pipe();
    write_reg(gclk_pkg::RegGait, 20'hFFFFF);
    write_reg(gclk_pkg::RegStance, 20'd1);
    write_reg(gclk_pkg::RegOffset, 20'h8000);
    write_reg(gclk_pkg::RegSweep, 20'd0);
    send_word(32'd0, 20'h0, 16'h8000, 1'b0);
    send_word(32'd524287, 20'h0, 16'h0, 1'b0);
    send_word(32'hFFFF_FFFF, 20'h0, 16'h8000, 1'b0);
    drain_pipe();
    write_reg(gclk_pkg::RegGait, 20'd1);           // tiny cycle: every word is bad
    send_word(32'd77, 20'h0, 16'h0, 1'b0);
    drain_pipe();

    // Random phases with varied settings.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(gclk_pkg::RegSweep, 20'($urandom_range(0, 51471)));
      write_reg(gclk_pkg::RegOffset, 20'($urandom));
      write_reg(gclk_pkg::RegGait, 20'($urandom_range(2, 1048575)));
      write_reg(gclk_pkg::RegStance, 20'($urandom_range(1, gait_now - 1)));
      write_reg(gclk_pkg::RegTimeOff, 20'($urandom));
      nogap = (ph == 3);
      for (int k = 0; k < 100; k++) random_word(!nogap);
      // After every phase but the last, the sender waits for all results before carrying on.
      if (ph == 2) drain_pipe();
      else if (ph != 6) drain_pipe();
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Cycle limit and verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/gclk_pkg.sv
rtl/gait_clock_leg_angle.sv
rtl/gclk_chk.sv
tb/sv/gait_clock_checker.sv
tb/sv/tb_gait_clock_leg_angle.sv
